/* rtl/rsma_pkg.sv */
package rsma_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int SUM_W          = 21;
    localparam int CFG_W          = 6;
    localparam int STEP_W         = $clog2(SUM_W);
    localparam int MAX_WINDOW_DEF = 32;

    localparam logic [CFG_W-1:0] COUNT_MAX    = CFG_W'(63);
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first_of_sequence;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smoothed;
        logic                       is_average;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic will_avg;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/running_sum_moving_average.sv */
// Channel  Direction  Handshake                  Data
// in       input      i_in_valid / o_in_ready    i_in_data (t_in_word)
// out      output     o_out_valid / i_out_ready  o_out_data (t_out_word)
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (window length)
//
// An averaged word goes through accepting it and reading the ring, updating the
// sum, 21 steps of the restoring divider and loading the output register; a
// passthrough word skips the divider. The block takes no new word until the
// current one is loaded.
// Synchronous active-low reset clears the sum, count, pointer and handshakes
// and sets the window length to 3. The next word is taken while a result still
// waits in the output register; a stalled output holds the block before its load.
module running_sum_moving_average
    import rsma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    rsma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rsma_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

/* rtl/rsma_ctrl.sv */
module rsma_ctrl
    import rsma_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIVIDE,
        S_FINISH
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_step       = '0;
                n_state      = i_status.will_avg ? S_DIVIDE : S_FINISH;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef SYNTH
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.update, o_cmd.div_step, o_cmd.load_out}))
        else $error("more than one datapath command at once");
    a_accept_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.update)
        else $error("accepted word not followed by an update");
    a_divide_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_step && r_step == LAST_STEP) |=> !o_cmd.div_step)
        else $error("divider ran past its last step");
`endif

endmodule

/* rtl/rsma_dp.sv */
module rsma_dp
    import rsma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_in_word         i_in_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_out_word        o_out_data,
    input  t_ctrl_cmd        i_cmd,
    output t_dp_status       o_status
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int AW    = ((PTR_W > CFG_W) ? PTR_W : CFG_W) + 1;
    localparam logic [CFG_W-1:0] LEN_CLAMP = CFG_W'((MAX_WINDOW > 63) ? 63 : MAX_WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(MAX_WINDOW - 1);
    localparam logic [AW-1:0]    DEPTH_EXT = AW'(MAX_WINDOW);
    localparam logic [SUM_W-1:0] POS_LIMIT = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic [SUM_W-1:0] NEG_LIMIT = SUM_W'(1 << (SAMPLE_W - 1));

    logic [CFG_W-1:0]          r_window_len;
    logic [CFG_W-1:0]          eff_len;

    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_first;
    logic signed [SAMPLE_W-1:0] r_rd;
    logic [SAMPLE_W-1:0]        r_hist [MAX_WINDOW];

    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic [CFG_W-1:0]           r_count;
    logic [CFG_W-1:0]           n_count;
    logic [PTR_W-1:0]           r_wp;
    logic [PTR_W-1:0]           n_wp;
    logic [PTR_W-1:0]           wr_addr;

    logic [PTR_W-1:0]           wp_base;
    logic [AW-1:0]              rd_full;
    logic [PTR_W-1:0]           rd_addr;
    logic signed [SUM_W-1:0]    sum_base;
    logic [CFG_W-1:0]           count_base;
    logic signed [SUM_W-1:0]    sub_val;

    logic                       r_avg;
    logic                       r_neg;
    logic [SUM_W-1:0]           r_dq;
    logic [CFG_W-1:0]           r_rem;
    logic [CFG_W:0]             trial;
    logic                       q_bit;

    logic                       r_out_valid;
    t_out_word                  r_out_data;
    logic signed [SAMPLE_W-1:0] avg_val;

    // Length zero counts as one, and lengths beyond the ring saturate.
    always_comb begin
        eff_len = r_window_len;
        if (r_window_len == '0) begin
            eff_len = CFG_W'(1);
        end else if (r_window_len > LEN_CLAMP) begin
            eff_len = LEN_CLAMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            r_window_len <= i_cfg_data;
        end
    end

    // The leaving sample sits eff_len slots behind the write pointer.
    assign wp_base = i_in_data.first_of_sequence ? '0 : r_wp;
    assign rd_full = (AW'(wp_base) >= AW'(eff_len))
                   ? AW'(wp_base) - AW'(eff_len)
                   : AW'(wp_base) + DEPTH_EXT - AW'(eff_len);
    assign rd_addr = rd_full[PTR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x     <= i_in_data.sample;
            r_first <= i_in_data.first_of_sequence;
            r_rd    <= r_hist[rd_addr];
        end
    end

    // The first sample of a sequence goes to slot zero.
    assign wr_addr = r_first ? '0 : r_wp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_hist[wr_addr] <= r_x;
        end
    end

    // A new sequence clears count, sum and pointer before its first sample.
    always_comb begin
        sum_base   = r_first ? '0 : r_sum;
        count_base = r_first ? '0 : r_count;
        sub_val    = (count_base >= eff_len) ? SUM_W'(r_rd) : '0;
        n_sum      = sum_base - sub_val + SUM_W'(r_x);
        n_count    = (count_base == COUNT_MAX) ? COUNT_MAX : count_base + CFG_W'(1);
        n_wp       = (r_wp == PTR_LAST || r_first) ? (r_first ? PTR_W'(1) : '0)
                                                   : r_wp + PTR_W'(1);
        if (r_first && PTR_LAST == '0) begin
            n_wp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_wp    <= '0;
        end else if (i_cmd.update) begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_wp    <= n_wp;
        end
    end

    // Restoring divide of the sum magnitude, one quotient bit per step.
    assign trial = {r_rem, r_dq[SUM_W-1]} - {1'b0, eff_len};
    assign q_bit = !trial[CFG_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_avg <= (n_count >= eff_len);
            r_neg <= n_sum[SUM_W-1];
            r_dq  <= n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? trial[CFG_W-1:0] : {r_rem[CFG_W-2:0], r_dq[SUM_W-1]};
            r_dq  <= {r_dq[SUM_W-2:0], q_bit};
        end
    end

    always_comb begin
        if (r_neg) begin
            avg_val = (r_dq > NEG_LIMIT) ? SAMPLE_W'(NEG_LIMIT)
                                         : SAMPLE_W'(-r_dq);
        end else begin
            avg_val = (r_dq > POS_LIMIT) ? SAMPLE_W'(POS_LIMIT)
                                         : SAMPLE_W'(r_dq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.smoothed   <= r_avg ? avg_val : r_x;
            r_out_data.is_average <= r_avg;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_status.will_avg = (n_count >= eff_len);
    assign o_status.out_free = !r_out_valid || i_out_ready;

`ifndef SYNTH
    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten before it was taken");
    a_remainder_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_rem < eff_len))
        else $error("divider remainder not below the window length");
    a_pointer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= PTR_LAST)
        else $error("write pointer beyond the ring");
`endif

endmodule
